// ----- rtl/core/yuv422_to_rgb_pixel_pair_assert.svh -----
// assertion macros for the yuv422 to rgb pixel pair block
`ifndef YUV422_TO_RGB_PIXEL_PAIR_ASSERT_SVH
`define YUV422_TO_RGB_PIXEL_PAIR_ASSERT_SVH

// condition holds on every edge out of reset
`define YRGB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds on the edge after the antecedent, reset included
`define YRGB_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/yrgb_pkg.sv -----
// shared types and constants for the yuv422 to rgb pixel pair pipeline
`default_nettype none
package yrgb_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned OfsW  = 9;
    localparam int unsigned ProdW = 18;
    localparam int unsigned TermW = 19;
    localparam int unsigned SumW  = 20;

    localparam logic signed [OfsW-1:0]  LumaOfs    = 9'sd16;
    localparam logic signed [OfsW-1:0]  ChromaOfs  = 9'sd128;
    localparam logic signed [ProdW-1:0] CoefLuma   = 18'sd298;
    localparam logic signed [ProdW-1:0] CoefBlue   = 18'sd516;
    localparam logic signed [ProdW-1:0] CoefRed    = 18'sd409;
    localparam logic signed [ProdW-1:0] CoefGreenB = 18'sd100;
    localparam logic signed [ProdW-1:0] CoefGreenR = 18'sd208;
    localparam logic signed [TermW-1:0] RoundAdd   = 19'sd128;
    localparam logic [ByteW-1:0]        ChMax      = 8'd255;

    typedef struct packed {
        logic [ByteW-1:0]        grey_first;
        logic [ByteW-1:0]        grey_second;
        logic signed [ProdW-1:0] luma_first;
        logic signed [ProdW-1:0] luma_second;
        logic signed [ProdW-1:0] blue_cb;
        logic signed [ProdW-1:0] green_cb;
        logic signed [ProdW-1:0] green_cr;
        logic signed [ProdW-1:0] red_cr;
    } prod_t;

    typedef struct packed {
        logic [ByteW-1:0]        grey_first;
        logic [ByteW-1:0]        grey_second;
        logic signed [ProdW-1:0] luma_first;
        logic signed [ProdW-1:0] luma_second;
        logic signed [TermW-1:0] blue_term;
        logic signed [TermW-1:0] green_term;
        logic signed [TermW-1:0] red_term;
    } term_t;

    typedef struct packed {
        logic [ByteW-1:0]       grey_first;
        logic [ByteW-1:0]       grey_second;
        logic signed [SumW-1:0] blue_first;
        logic signed [SumW-1:0] green_first;
        logic signed [SumW-1:0] red_first;
        logic signed [SumW-1:0] blue_second;
        logic signed [SumW-1:0] green_second;
        logic signed [SumW-1:0] red_second;
    } chan_t;

    typedef struct packed {
        logic [ByteW-1:0] blue_first;
        logic [ByteW-1:0] green_first;
        logic [ByteW-1:0] red_first;
        logic [ByteW-1:0] blue_second;
        logic [ByteW-1:0] green_second;
        logic [ByteW-1:0] red_second;
        logic [ByteW-1:0] grey_first;
        logic [ByteW-1:0] grey_second;
    } pix_t;

    // floor of sum / 256, clamped to 0..255
    function automatic logic [ByteW-1:0] shift_clamp(input logic signed [SumW-1:0] sum);
        logic [ByteW-1:0] res;
        if (sum[SumW-1]) begin
            res = '0;
        end else if (sum[SumW-2:2*ByteW] != '0) begin
            res = ChMax;
        end else begin
            res = sum[2*ByteW-1:ByteW];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/yrgb_product.sv -----
// stage one: offset removal and constant products
`default_nettype none
module yrgb_product (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [yrgb_pkg::ByteW-1:0]    luma_first,
    input  wire logic [yrgb_pkg::ByteW-1:0]    chroma_red_side,
    input  wire logic [yrgb_pkg::ByteW-1:0]    luma_second,
    input  wire logic [yrgb_pkg::ByteW-1:0]    chroma_blue_side,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output yrgb_pkg::prod_t                    out_data
);

    logic                  valid_reg;
    yrgb_pkg::prod_t       data_reg;
    yrgb_pkg::prod_t       data_next;
    logic signed [yrgb_pkg::OfsW-1:0] y1;
    logic signed [yrgb_pkg::OfsW-1:0] y2;
    logic signed [yrgb_pkg::OfsW-1:0] cr;
    logic signed [yrgb_pkg::OfsW-1:0] cb;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        y1 = $signed({1'b0, luma_first}) - yrgb_pkg::LumaOfs;
        y2 = $signed({1'b0, luma_second}) - yrgb_pkg::LumaOfs;
        cr = $signed({1'b0, chroma_red_side}) - yrgb_pkg::ChromaOfs;
        cb = $signed({1'b0, chroma_blue_side}) - yrgb_pkg::ChromaOfs;
        data_next.grey_first  = luma_first;
        data_next.grey_second = luma_second;
        data_next.luma_first  = yrgb_pkg::ProdW'(y1) * yrgb_pkg::CoefLuma;
        data_next.luma_second = yrgb_pkg::ProdW'(y2) * yrgb_pkg::CoefLuma;
        data_next.blue_cb     = yrgb_pkg::ProdW'(cb) * yrgb_pkg::CoefBlue;
        data_next.green_cb    = yrgb_pkg::ProdW'(cb) * yrgb_pkg::CoefGreenB;
        data_next.green_cr    = yrgb_pkg::ProdW'(cr) * yrgb_pkg::CoefGreenR;
        data_next.red_cr      = yrgb_pkg::ProdW'(cr) * yrgb_pkg::CoefRed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/yrgb_term.sv -----
// stage two: chroma terms with rounding
`default_nettype none
module yrgb_term (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire yrgb_pkg::prod_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output yrgb_pkg::term_t      out_data
);

    logic            valid_reg;
    yrgb_pkg::term_t data_reg;
    yrgb_pkg::term_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.grey_first  = in_data.grey_first;
        data_next.grey_second = in_data.grey_second;
        data_next.luma_first  = in_data.luma_first;
        data_next.luma_second = in_data.luma_second;
        data_next.blue_term   = yrgb_pkg::TermW'(in_data.blue_cb) + yrgb_pkg::RoundAdd;
        data_next.green_term  = yrgb_pkg::RoundAdd - yrgb_pkg::TermW'(in_data.green_cb)
                                - yrgb_pkg::TermW'(in_data.green_cr);
        data_next.red_term    = yrgb_pkg::TermW'(in_data.red_cr) + yrgb_pkg::RoundAdd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/yrgb_channel.sv -----
// stage three: luma plus chroma term per channel
`default_nettype none
module yrgb_channel (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire yrgb_pkg::term_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output yrgb_pkg::chan_t      out_data
);

    logic            valid_reg;
    yrgb_pkg::chan_t data_reg;
    yrgb_pkg::chan_t data_next;
    logic signed [yrgb_pkg::SumW-1:0] l1;
    logic signed [yrgb_pkg::SumW-1:0] l2;
    logic signed [yrgb_pkg::SumW-1:0] tb;
    logic signed [yrgb_pkg::SumW-1:0] tg;
    logic signed [yrgb_pkg::SumW-1:0] tr;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        l1 = yrgb_pkg::SumW'(in_data.luma_first);
        l2 = yrgb_pkg::SumW'(in_data.luma_second);
        tb = yrgb_pkg::SumW'(in_data.blue_term);
        tg = yrgb_pkg::SumW'(in_data.green_term);
        tr = yrgb_pkg::SumW'(in_data.red_term);
        data_next.grey_first   = in_data.grey_first;
        data_next.grey_second  = in_data.grey_second;
        data_next.blue_first   = l1 + tb;
        data_next.green_first  = l1 + tg;
        data_next.red_first    = l1 + tr;
        data_next.blue_second  = l2 + tb;
        data_next.green_second = l2 + tg;
        data_next.red_second   = l2 + tr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/yrgb_clamp.sv -----
// stage four: shift, clamp and output register
`default_nettype none
module yrgb_clamp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire yrgb_pkg::chan_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output yrgb_pkg::pix_t       out_data
);

    logic           valid_reg;
    yrgb_pkg::pix_t data_reg;
    yrgb_pkg::pix_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.blue_first   = yrgb_pkg::shift_clamp(in_data.blue_first);
        data_next.green_first  = yrgb_pkg::shift_clamp(in_data.green_first);
        data_next.red_first    = yrgb_pkg::shift_clamp(in_data.red_first);
        data_next.blue_second  = yrgb_pkg::shift_clamp(in_data.blue_second);
        data_next.green_second = yrgb_pkg::shift_clamp(in_data.green_second);
        data_next.red_second   = yrgb_pkg::shift_clamp(in_data.red_second);
        data_next.grey_first   = in_data.grey_first;
        data_next.grey_second  = in_data.grey_second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/yuv422_to_rgb_pixel_pair.sv -----
// each input transaction is registered in the product, term, channel and clamp stages, in that order
// throughput: one packed word per cycle while m_ready is high, set by the four-stage register pipeline
// each stage takes a transaction whenever it is empty or its successor is taking one
// reset (aresetn low, synchronous) empties every stage; data registers are not cleared
`default_nettype none
`include "yuv422_to_rgb_pixel_pair_assert.svh"
module yuv422_to_rgb_pixel_pair (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_luma_first,
    input  wire logic [7:0] s_chroma_red_side,
    input  wire logic [7:0] s_luma_second,
    input  wire logic [7:0] s_chroma_blue_side,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_blue_first,
    output logic [7:0]      m_green_first,
    output logic [7:0]      m_red_first,
    output logic [7:0]      m_blue_second,
    output logic [7:0]      m_green_second,
    output logic [7:0]      m_red_second,
    output logic [7:0]      m_grey_first,
    output logic [7:0]      m_grey_second
);

    logic            prod_valid;
    logic            prod_ready;
    yrgb_pkg::prod_t prod_data;
    logic            term_valid;
    logic            term_ready;
    yrgb_pkg::term_t term_data;
    logic            chan_valid;
    logic            chan_ready;
    yrgb_pkg::chan_t chan_data;
    yrgb_pkg::pix_t  pix_data;

    yrgb_product u_product (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .luma_first       (s_luma_first),
        .chroma_red_side  (s_chroma_red_side),
        .luma_second      (s_luma_second),
        .chroma_blue_side (s_chroma_blue_side),
        .out_valid        (prod_valid),
        .out_ready        (prod_ready),
        .out_data         (prod_data)
    );

    yrgb_term u_term (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    yrgb_channel u_channel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (chan_valid),
        .out_ready (chan_ready),
        .out_data  (chan_data)
    );

    yrgb_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chan_valid),
        .in_ready  (chan_ready),
        .in_data   (chan_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (pix_data)
    );

    assign m_blue_first   = pix_data.blue_first;
    assign m_green_first  = pix_data.green_first;
    assign m_red_first    = pix_data.red_first;
    assign m_blue_second  = pix_data.blue_second;
    assign m_green_second = pix_data.green_second;
    assign m_red_second   = pix_data.red_second;
    assign m_grey_first   = pix_data.grey_first;
    assign m_grey_second  = pix_data.grey_second;

    // a free output lets the whole pipeline advance
    `YRGB_ASSERT_ALWAYS(a_ready_chain, aclk, aresetn, !m_ready || s_ready)
    `YRGB_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid && !chan_valid && !term_valid)
    `YRGB_ASSERT_NEXT(a_chan_moves, aclk, aresetn && chan_valid && chan_ready, m_valid)

endmodule
`default_nettype wire
